@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker emm_chk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define AST_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed (same cycle)");

// Next-cycle implication, held off during reset.
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed (next cycle)");

`endif

@@ hw/rtl/emm_pkg.sv @@
// ----------------------------------------------------------------------------
// emm_pkg
// Shared constants for the expiring message mailbox.
// ----------------------------------------------------------------------------
package emm_pkg;

  localparam int ENTRIES_DEF       = 16;
  localparam int PAYLOAD_BYTES_DEF = 8;

  localparam int OP_W       = 1;
  localparam int TIME_W     = 48;
  localparam int PID_W      = 16;
  localparam int TYPE_W     = 8;
  localparam int DATA_W     = 64;
  localparam int STATUS_W   = 2;
  localparam int LIFETIME_W = 32;

  localparam logic [LIFETIME_W-1:0] LIFETIME_RST = 32'd1000;

  // input tdata layout, lowest bit first
  localparam int IN_NOW_LSB    = 0;
  localparam int IN_CALLER_LSB = IN_NOW_LSB + TIME_W;
  localparam int IN_TARGET_LSB = IN_CALLER_LSB + PID_W;
  localparam int IN_WANTED_LSB = IN_TARGET_LSB + PID_W;
  localparam int IN_DATA_LSB   = IN_WANTED_LSB + TYPE_W;
  localparam int IN_TDATA_W    = IN_DATA_LSB + DATA_W;

  // output tdata layout, lowest bit first
  localparam int OUT_SRC_LSB  = 0;
  localparam int OUT_DATA_LSB = OUT_SRC_LSB + PID_W;
  localparam int OUT_TDATA_W  = OUT_DATA_LSB + DATA_W;

  localparam logic [OP_W-1:0] OP_SEND = 1'b0;
  localparam logic [OP_W-1:0] OP_RECV = 1'b1;

  localparam logic [STATUS_W-1:0] ST_SENT = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RECV = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } emm_state_t;

endpackage

@@ hw/rtl/expiring_message_mailbox.sv @@
// ----------------------------------------------------------------------------
// expiring_message_mailbox
// Mailbox table of ENTRIES slots whose messages expire at a deadline.
// ----------------------------------------------------------------------------
// Input beats carry a request: in_tuser selects send (0) or receive (1), and
// in_tdata carries the time, pids, type filter and payload. Each request gives
// one result beat: out_tuser holds the status (sent, full, received, none),
// out_tdata the sender and payload of a received message, zero otherwise.
// cfg_wr_en/cfg_wr_data set the message lifetime; write only while idle.
// A request scans the slots one per cycle through a single 49-bit subtractor
// that gives both the below-now and above-now tests against the slot's
// deadline, read from a RAM with registered output. A request goes through an
// issue step, a scan of the slots that stops at the first hit, and a result
// step; in_tready is low from acceptance until the result is in the
// output register. Reset frees every slot at once (per-slot live bits) and
// sets the lifetime to 1000. When the receiver stalls, the result beat is held
// in the output register and a finished request waits in the result stage
// until it drains.
// ----------------------------------------------------------------------------
module expiring_message_mailbox #(
  parameter int ENTRIES       = emm_pkg::ENTRIES_DEF,
  parameter int PAYLOAD_BYTES = emm_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // now_time[47:0], caller_pid[63:48], target_pid[79:64], wanted_type[87:80],
  // message_data[151:88]
  input  logic [emm_pkg::IN_TDATA_W-1:0]   in_tdata,
  // operation[0]
  input  logic [emm_pkg::OP_W-1:0]         in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // entry_source[15:0], entry_data[79:16]
  output logic [emm_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // status[1:0]
  output logic [emm_pkg::STATUS_W-1:0]     out_tuser,
  input  logic                             cfg_wr_en,
  input  logic [emm_pkg::LIFETIME_W-1:0]   cfg_wr_data
);

  import emm_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PW = PAYLOAD_BYTES * 8;
  localparam int MW = 2 * PID_W + PW;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  emm_state_t            state_r, state_nxt;
  logic [IW-1:0]         chk_idx_r, chk_idx_nxt;
  logic [OP_W-1:0]       op_r;
  logic [TIME_W-1:0]     now_r;
  logic [PID_W-1:0]      caller_r;
  logic [PID_W-1:0]      target_r;
  logic [TYPE_W-1:0]     wanted_r;
  logic [PW-1:0]         payload_r;
  logic [TIME_W-1:0]     dl_new_r;
  logic [LIFETIME_W-1:0] lifetime_r;
  logic [ENTRIES-1:0]    valid_r, valid_nxt;

  logic [STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic [PID_W-1:0]      res_src_r, res_src_nxt;
  logic [PW-1:0]         res_data_r, res_data_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r;
  logic [PID_W-1:0]      out_src_r;
  logic [DATA_W-1:0]     out_data_r;

  logic                  accept;
  logic                  out_load;
  logic [TIME_W:0]       dl_sum;
  logic [IW-1:0]         rd_addr;
  logic [TIME_W-1:0]     dl_rdata;
  logic [MW-1:0]         msg_rdata;
  logic [MW-1:0]         msg_wdata;
  logic                  ram_we;

  logic                  cur_vld;
  logic [TIME_W:0]       diff;
  logic                  dl_gt_now;
  logic                  dl_lt_now;
  logic [PID_W-1:0]      cur_sender;
  logic [PID_W-1:0]      cur_target;
  logic [PW-1:0]         cur_payload;
  logic                  send_hit;
  logic                  recv_hit;
  logic                  hit;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // saturating deadline, worked out once at issue
  assign dl_sum = {1'b0, in_tdata[IN_NOW_LSB +: TIME_W]} + (TIME_W + 1)'(lifetime_r);

  // read one slot ahead of the one being checked
  assign rd_addr = (state_r == S_IDLE) ? '0 : chk_idx_r + 1'b1;

  assign msg_wdata = {payload_r, target_r, caller_r};

  emm_ram #(.WIDTH(TIME_W), .DEPTH(ENTRIES)) u_dl_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (chk_idx_r),
    .wr_data (dl_new_r),
    .rd_en   (1'b1),
    .rd_addr (rd_addr),
    .rd_data (dl_rdata)
  );

  emm_ram #(.WIDTH(MW), .DEPTH(ENTRIES)) u_msg_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (chk_idx_r),
    .wr_data (msg_wdata),
    .rd_en   (1'b1),
    .rd_addr (rd_addr),
    .rd_data (msg_rdata)
  );

  // shared compare: one subtract gives both orderings; a dead slot reads as 0
  always_comb begin
    cur_vld     = valid_r[chk_idx_r];
    diff        = {1'b0, now_r} - {1'b0, (cur_vld ? dl_rdata : {TIME_W{1'b0}})};
    dl_gt_now   = diff[TIME_W];
    dl_lt_now   = !diff[TIME_W] && (diff[TIME_W-1:0] != '0);
    cur_sender  = msg_rdata[PID_W-1:0];
    cur_target  = msg_rdata[2*PID_W-1:PID_W];
    cur_payload = msg_rdata[MW-1:2*PID_W];
    send_hit    = dl_lt_now;
    recv_hit    = cur_vld && dl_gt_now && (cur_target == caller_r) &&
                  ((wanted_r == '0) || (cur_payload[TYPE_W-1:0] == wanted_r));
    hit         = (op_r == OP_SEND) ? send_hit : recv_hit;
  end

  assign ram_we   = (state_r == S_SCAN) && hit && (op_r == OP_SEND);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt      = state_r;
    chk_idx_nxt    = chk_idx_r;
    valid_nxt      = valid_r;
    res_status_nxt = res_status_r;
    res_src_nxt    = res_src_r;
    res_data_nxt   = res_data_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          chk_idx_nxt = '0;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        chk_idx_nxt = chk_idx_r + 1'b1;
        if (hit || (chk_idx_r == LAST_IDX)) begin
          state_nxt    = S_DONE;
          res_src_nxt  = '0;
          res_data_nxt = '0;
          if (op_r == OP_SEND) begin
            res_status_nxt = hit ? ST_SENT : ST_FULL;
            if (hit) begin
              valid_nxt[chk_idx_r] = 1'b1;
            end
          end else if (hit) begin
            res_status_nxt       = ST_RECV;
            res_src_nxt          = cur_sender;
            res_data_nxt         = cur_payload;
            valid_nxt[chk_idx_r] = 1'b0;
          end else begin
            res_status_nxt = ST_NONE;
          end
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      lifetime_r  <= LIFETIME_RST;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        lifetime_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r    <= chk_idx_nxt;
    res_status_r <= res_status_nxt;
    res_src_r    <= res_src_nxt;
    res_data_r   <= res_data_nxt;
    if (accept) begin
      op_r      <= in_tuser;
      now_r     <= in_tdata[IN_NOW_LSB +: TIME_W];
      caller_r  <= in_tdata[IN_CALLER_LSB +: PID_W];
      target_r  <= in_tdata[IN_TARGET_LSB +: PID_W];
      wanted_r  <= in_tdata[IN_WANTED_LSB +: TYPE_W];
      payload_r <= in_tdata[IN_DATA_LSB +: PW];
      dl_new_r  <= dl_sum[TIME_W] ? {TIME_W{1'b1}} : dl_sum[TIME_W-1:0];
    end
    if (out_load) begin
      out_status_r <= res_status_r;
      out_src_r    <= res_src_r;
      out_data_r   <= DATA_W'(res_data_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {out_data_r, out_src_r};

endmodule

@@ hw/rtl/emm_ram.sv @@
// ----------------------------------------------------------------------------
// emm_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module emm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

@@ hw/rtl/emm_chk.sv @@
// ----------------------------------------------------------------------------
// emm_chk
// Port-level checks for the expiring message mailbox, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module emm_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [emm_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [emm_pkg::STATUS_W-1:0]    out_tuser
);

  import emm_pkg::*;

  // a stalled result beat holds
  `AST_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
            out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // one request at a time: busy straight after a beat is taken
  `AST_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)

  // only a received message carries data
  `AST_IMPLY(a_zero_payload, clk, rst_n, out_tvalid && (out_tuser != ST_RECV), out_tdata == '0)

endmodule

bind expiring_message_mailbox emm_chk u_emm_chk (.*);
